### rtl/ttw_pkg.sv
// shared types and constants for the text terminal writer
`timescale 1ns / 1ps
package ttw_pkg;
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] CH_BS       = 8'd8;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] RESET_COLOR = 8'd15;

    typedef enum logic [2:0] {
        REQ_PUT_CUR = 3'd0,
        REQ_PUT_POS = 3'd1,
        REQ_SET_CUR = 3'd2,
        REQ_CLEAR   = 3'd3,
        REQ_READ    = 3'd4
    } t_req;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0] req;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
        logic       pos_ok;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_WRITE, ST_RD_WAIT, ST_RD_DONE,
        ST_CHECK, ST_SCR_RD, ST_SCR_WR, ST_SCR_BLANK, ST_CLEAR, ST_OUT
    } t_state;
endpackage

### rtl/text_terminal_writer.sv
// top level of the text terminal writer
// flow: the back end takes a command from the front queue in ST_IDLE; set cursor, unused types
// and out-of-range reads go straight to ST_OUT, put at position writes first, put at cursor also
// checks for a scroll and read cell waits on the store read; scroll and clear sweep the store
// throughput: one transaction at a time in the back end, a two entry queue in front
// reset: synchronous active low; a blanking pass over every cell runs before any request is executed
`timescale 1ns / 1ps
module text_terminal_writer import ttw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_char_color,
    input  logic [6:0]  i_pos_col,
    input  logic [4:0]  i_pos_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cursor_col_out,
    output logic [4:0]  o_cursor_row_out,
    output logic [10:0] o_cursor_offset,
    output logic [15:0] o_cell_data,
    output logic        o_scrolled
);
    logic [7:0] r_color;
    logic       w_cmd_valid, w_cmd_ready;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_color <= RESET_COLOR;
        else if (i_cfg_we) r_color <= i_cfg_data;
    end

    ttw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_req_type, .i_char_code, .i_char_color, .i_pos_col, .i_pos_row,
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    ttw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
        .i_clk, .i_rst_n, .i_color(r_color),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_cursor_col_out, .o_cursor_row_out,
        .o_cursor_offset, .o_cell_data, .o_scrolled
    );
endmodule

### rtl/ttw_front.sv
// request intake: range check and a two entry command queue
`timescale 1ns / 1ps
module ttw_front import ttw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_char_color,
    input  logic [6:0] i_pos_col,
    input  logic [4:0] i_pos_row,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.req    = i_req_type;
        w_cmd.ch     = i_char_code;
        w_cmd.attr   = i_char_color;
        w_cmd.col    = i_pos_col;
        w_cmd.row    = i_pos_row;
        w_cmd.pos_ok = ({25'd0, i_pos_col} < COLUMNS) && ({27'd0, i_pos_row} < ROWS);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### rtl/ttw_back.sv
// command execution: screen store, cursor, scroll and clear sweeps
`timescale 1ns / 1ps
module ttw_back import ttw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_color,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cursor_col_out,
    output logic [4:0]  o_cursor_row_out,
    output logic [10:0] o_cursor_offset,
    output logic [15:0] o_cell_data,
    output logic        o_scrolled
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int LAST  = CELLS - 1;
    localparam int BODY  = (ROWS - 1) * COLUMNS;

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rdata;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [6:0]  r_col, n_col;
    logic [4:0]  r_row, n_row;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [15:0] r_cell, n_cell;
    logic        r_scr, n_scr;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_cur_addr, w_pos_addr;
    logic [15:0]   w_blank;
    logic [7:0]    w_tab;
    logic          w_adv;

    assign w_blank    = {i_color, BLANK_CHAR};
    assign w_cur_addr = AW'({25'd0, r_row} * COLUMNS + {25'd0, r_col});
    assign w_pos_addr = AW'({25'd0, r_cmd.row} * COLUMNS + {25'd0, r_cmd.col});
    assign w_tab      = ({1'b0, r_col} + 8'd4) & ~8'd3;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:  if (r_ptr == AW'(LAST)) n_state = ST_IDLE;
            ST_IDLE:  if (i_cmd_valid) begin
                unique case (i_cmd.req)
                    REQ_PUT_CUR: n_state = ST_WRITE;
                    REQ_PUT_POS: n_state = ST_WRITE;
                    REQ_CLEAR:   n_state = ST_CLEAR;
                    REQ_READ:    n_state = i_cmd.pos_ok ? ST_RD_WAIT : ST_OUT;
                    default:     n_state = ST_OUT;
                endcase
            end
            ST_WRITE:     n_state = (r_cmd.req == REQ_PUT_CUR) ? ST_CHECK : ST_OUT;
            ST_RD_WAIT:   n_state = ST_RD_DONE;
            ST_RD_DONE:   n_state = ST_OUT;
            ST_CHECK:     n_state = r_scr ? ST_SCR_RD : ST_OUT;
            ST_SCR_RD:    n_state = ST_SCR_WR;
            ST_SCR_WR:    n_state = (r_ptr == AW'(BODY - 1)) ? ST_SCR_BLANK : ST_SCR_RD;
            ST_SCR_BLANK: if (r_ptr == AW'(LAST)) n_state = ST_OUT;
            ST_CLEAR:     if (r_ptr == AW'(LAST)) n_state = ST_OUT;
            ST_OUT:       if (i_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ptr = r_ptr;
        n_cell = r_cell;
        n_scr = r_scr;
        w_we = 1'b0;
        w_re = 1'b0;
        w_waddr = r_ptr;
        w_raddr = r_ptr;
        w_wdata = w_blank;
        w_adv = 1'b0;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                w_we = 1'b1;
                n_ptr = r_ptr + AW'(1);
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                n_ptr = '0;
                n_cell = 16'd0;
                n_scr = 1'b0;
                if (i_cmd_valid && i_cmd.req == REQ_SET_CUR) begin
                    n_col = ({25'd0, i_cmd.col} >= COLUMNS) ? 7'(COLUMNS - 1) : i_cmd.col;
                    n_row = ({27'd0, i_cmd.row} >= ROWS) ? 5'(ROWS - 1) : i_cmd.row;
                end
            end
            ST_WRITE: begin
                if (r_cmd.req == REQ_PUT_POS) begin
                    w_we = r_cmd.pos_ok;
                    w_waddr = w_pos_addr;
                    w_wdata = {r_cmd.attr, r_cmd.ch};
                end else begin
                    w_waddr = w_cur_addr;
                    priority if (r_cmd.ch == CH_LF) begin
                        n_col = 7'd0;
                        w_adv = 1'b1;
                    end else if (r_cmd.ch == CH_CR) begin
                        n_col = 7'd0;
                    end else if (r_cmd.ch == CH_TAB) begin
                        n_col = w_tab[6:0];
                        if ({24'd0, w_tab} >= COLUMNS) begin
                            n_col = 7'd0;
                            w_adv = 1'b1;
                        end
                    end else if (r_cmd.ch == CH_BS) begin
                        if (r_col != 7'd0) begin
                            n_col = r_col - 7'd1;
                            w_we = 1'b1;
                            w_waddr = w_cur_addr - AW'(1);
                        end
                    end else begin
                        w_we = 1'b1;
                        w_wdata = {i_color, r_cmd.ch};
                        n_col = r_col + 7'd1;
                        if ({25'd0, r_col} + 1 >= COLUMNS) begin
                            n_col = 7'd0;
                            w_adv = 1'b1;
                        end
                    end
                    // row compare kept wide so the last row never wraps the counter
                    if (w_adv) begin
                        if ({27'd0, r_row} + 1 >= ROWS) begin
                            n_row = 5'(ROWS - 1);
                            n_scr = 1'b1;
                        end else begin
                            n_row = r_row + 5'd1;
                        end
                    end
                end
            end
            ST_RD_WAIT: begin
                w_re = 1'b1;
                w_raddr = w_pos_addr;
            end
            ST_RD_DONE: n_cell = r_rdata;
            ST_SCR_RD: begin
                w_re = 1'b1;
                w_raddr = r_ptr + AW'(COLUMNS);
            end
            ST_SCR_WR: begin
                w_we = 1'b1;
                w_wdata = r_rdata;
                n_ptr = r_ptr + AW'(1);
            end
            ST_SCR_BLANK, ST_CLEAR: begin
                w_we = 1'b1;
                n_ptr = r_ptr + AW'(1);
                if (r_state == ST_CLEAR) begin
                    n_col = 7'd0;
                    n_row = 5'd0;
                end
            end
            ST_CHECK, ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        r_cell <= n_cell;
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_col   <= 7'd0;
            r_row   <= 5'd0;
            r_scr   <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_scr   <= n_scr;
            r_ptr   <= n_ptr;
        end
    end

    assign o_valid          = (r_state == ST_OUT);
    assign o_cursor_col_out = r_col;
    assign o_cursor_row_out = r_row;
    assign o_cursor_offset  = 11'({25'd0, r_row} * COLUMNS + {25'd0, r_col});
    assign o_cell_data      = r_cell;
    assign o_scrolled       = r_scr;
endmodule

### test/tb_text_terminal_writer.sv
// testbench for the text terminal writer: random and directed requests checked against a model
`timescale 1ns / 1ps
module tb_text_terminal_writer;
    import ttw_pkg::*;

    localparam int NCOL = DEF_COLUMNS;
    localparam int NROW = DEF_ROWS;
    localparam int NCELL = NCOL * NROW;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] offset;
        logic [15:0] cdata;
        logic        scrolled;
    } t_status;

    class terminal_scoreboard;
        logic [15:0] screen[NCELL];
        int unsigned cur_col;
        int unsigned cur_row;
        logic [7:0]  color;
        t_status     pending[$];
        int          errors;
        int          checked;
        int          scrolls;

        function void reset_state();
            color = RESET_COLOR;
            cur_col = 0;
            cur_row = 0;
            foreach (screen[i]) screen[i] = {color, BLANK_CHAR};
            pending.delete();
        endfunction

        function void set_color(logic [7:0] c);
            color = c;
        endfunction

        function void scroll_screen();
            for (int i = 0; i < (NROW - 1) * NCOL; i++) screen[i] = screen[i + NCOL];
            for (int i = 0; i < NCOL; i++) screen[(NROW - 1) * NCOL + i] = {color, BLANK_CHAR};
        endfunction

        function void note_request(logic [2:0] rq, logic [7:0] ch, logic [7:0] attr,
                                   logic [6:0] col, logic [4:0] row);
            t_status st;
            logic    did_scroll;
            logic [15:0] rd_val;
            did_scroll = 0;
            rd_val = '0;
            case (rq)
                REQ_PUT_CUR: begin
                    if (ch == CH_LF) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (ch == CH_CR) begin
                        cur_col = 0;
                    end else if (ch == CH_TAB) begin
                        cur_col = (cur_col + 4) & ~3;
                    end else if (ch == CH_BS) begin
                        if (cur_col > 0) begin
                            cur_col--;
                            screen[cur_row * NCOL + cur_col] = {color, BLANK_CHAR};
                        end
                    end else begin
                        screen[cur_row * NCOL + cur_col] = {color, ch};
                        cur_col++;
                    end
                    if (cur_col >= NCOL) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    if (cur_row >= NROW) begin
                        scroll_screen();
                        cur_row = NROW - 1;
                        did_scroll = 1;
                    end
                end
                REQ_PUT_POS: begin
                    if (col < NCOL && row < NROW) screen[row * NCOL + col] = {attr, ch};
                end
                REQ_SET_CUR: begin
                    cur_col = (col >= NCOL) ? NCOL - 1 : col;
                    cur_row = (row >= NROW) ? NROW - 1 : row;
                end
                REQ_CLEAR: begin
                    foreach (screen[i]) screen[i] = {color, BLANK_CHAR};
                    cur_col = 0;
                    cur_row = 0;
                end
                REQ_READ: begin
                    if (col < NCOL && row < NROW) rd_val = screen[row * NCOL + col];
                end
                default: ;
            endcase
            st.col = cur_col[6:0];
            st.row = cur_row[4:0];
            st.offset = 11'(cur_row * NCOL + cur_col);
            st.cdata = rd_val;
            st.scrolled = did_scroll;
            pending.push_back(st);
        endfunction

        function void check_status(t_status got);
            t_status exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.scrolled) scrolls++;
            if (got !== exp) begin
                $display("%0t: mismatch expected col %0d row %0d off %0d cell %h scr %0d",
                         $realtime, exp.col, exp.row, exp.offset, exp.cdata, exp.scrolled);
                $display("%0t:          actual col %0d row %0d off %0d cell %h scr %0d",
                         $realtime, got.col, got.row, got.offset, got.cdata, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  char_color;
    logic [6:0]  pos_col;
    logic [4:0]  pos_row;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  cur_col_o;
    logic [4:0]  cur_row_o;
    logic [10:0] cur_off_o;
    logic [15:0] cell_o;
    logic        scrolled_o;

    terminal_scoreboard sb;
    bit   sink_idle_on;
    bit   sink_hold;
    int   idle_cycles;
    int   sent;

    text_terminal_writer u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_req_type(req_type),
        .i_char_code(char_code), .i_char_color(char_color), .i_pos_col(pos_col),
        .i_pos_row(pos_row), .o_valid(out_valid), .i_ready(out_ready),
        .o_cursor_col_out(cur_col_o), .o_cursor_row_out(cur_row_o),
        .o_cursor_offset(cur_off_o), .o_cell_data(cell_o), .o_scrolled(scrolled_o)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side: sample, check, and drive ready for the next cycle
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                sb.check_status({cur_col_o, cur_row_o, cur_off_o, cell_o, scrolled_o});
            if (sink_hold) out_ready <= 1'b0;
            else if (sink_idle_on) out_ready <= ($urandom_range(99) >= 18);
            else out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $realtime);
                $display("tb_text_terminal_writer: done, errors");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    // valid stays up after a transaction only when the next one follows at once
    task automatic send_req(input logic [2:0] rq, input logic [7:0] ch, input logic [7:0] attr,
                            input logic [6:0] col, input logic [4:0] row, input bit gaps);
        while (gaps && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        char_code <= ch;
        char_color <= attr;
        pos_col <= col;
        pos_row <= row;
        do @(posedge clk); while (!in_ready);
        sb.note_request(rq, ch, attr, col, row);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2 * NCOL * NROW + 50) @(posedge clk);
    endtask

    task automatic write_color(input logic [7:0] c);
        cfg_we <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_color(c);
    endtask

    // mostly put at cursor with random bytes and line controls, some positioned and other requests
    task automatic random_req(input bit gaps);
        int unsigned pick;
        logic [7:0]  ch;
        pick = $urandom_range(99);
        ch = 8'($urandom);
        if (pick < 55) begin
            case ($urandom_range(9))
                0: ch = CH_LF;
                1: ch = CH_CR;
                2: ch = CH_TAB;
                3: ch = CH_BS;
                default: ;
            endcase
            send_req(REQ_PUT_CUR, ch, 8'($urandom), 7'($urandom), 5'($urandom), gaps);
        end else if (pick < 68) begin
            send_req(REQ_PUT_POS, ch, 8'($urandom),
                     7'($urandom_range(pick[0] ? 127 : NCOL - 1)),
                     5'($urandom_range(pick[1] ? 31 : NROW - 1)), gaps);
        end else if (pick < 80) begin
            send_req(REQ_READ, ch, 8'($urandom),
                     7'($urandom_range(pick[0] ? 127 : NCOL - 1)),
                     5'($urandom_range(pick[1] ? 31 : NROW - 1)), gaps);
        end else if (pick < 92) begin
            send_req(REQ_SET_CUR, ch, 8'($urandom), 7'($urandom),
                     5'($urandom_range(NROW + 6)), gaps);
        end else if (pick < 93) begin
            send_req(REQ_CLEAR, ch, 8'($urandom), 7'($urandom), 5'($urandom), gaps);
        end else begin
            send_req(3'($urandom_range(7)), ch, 8'($urandom), 7'($urandom), 5'($urandom),
                     gaps);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = '0;
        char_code = '0;
        char_color = '0;
        pos_col = '0;
        pos_row = '0;
        out_ready = 1'b0;
        sink_idle_on = 1'b1;
        sink_hold = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_PUT_CUR, 8'h41, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_PUT_CUR, 8'hFF, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_PUT_CUR, CH_TAB, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_PUT_CUR, CH_BS, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_READ, 8'h00, 8'h00, 7'd1, 5'd0, 0);
        send_req(REQ_PUT_CUR, CH_CR, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_PUT_CUR, CH_BS, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_PUT_POS, 8'h80, 8'hFF, 7'(NCOL - 1), 5'(NROW - 1), 0);
        send_req(REQ_PUT_POS, 8'h55, 8'hAA, 7'd127, 5'd31, 0);
        send_req(REQ_READ, 8'h00, 8'h00, 7'(NCOL - 1), 5'(NROW - 1), 0);
        send_req(REQ_READ, 8'h00, 8'h00, 7'd127, 5'd31, 0);
        send_req(REQ_SET_CUR, 8'h00, 8'h00, 7'd127, 5'd31, 0);
        send_req(REQ_PUT_CUR, 8'h7E, 8'h00, 7'd0, 5'd0, 0);   // wrap at the corner scrolls
        send_req(REQ_READ, 8'h00, 8'h00, 7'(NCOL - 1), 5'(NROW - 2), 0);
        send_req(REQ_SET_CUR, 8'h00, 8'h00, 7'(NCOL - 2), 5'(NROW - 1), 0);
        send_req(REQ_PUT_CUR, CH_TAB, 8'h00, 7'd0, 5'd0, 0);  // tab past the edge
        send_req(REQ_PUT_CUR, CH_LF, 8'h00, 7'd0, 5'd0, 0);
        send_req(3'd5, 8'h00, 8'h00, 7'd0, 5'd0, 0);
        send_req(3'd7, 8'h00, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0, 0);
        send_req(REQ_READ, 8'h00, 8'h00, 7'd3, 5'd3, 0);
        wait_drained();

        // random phases over several colors, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_color(8'h00);
                1: write_color(8'hFF);
                2: write_color(RESET_COLOR);
                default: write_color(8'($urandom));
            endcase
            if (ph == 1) begin
                // receiver stalls long while the sender keeps offering
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (300) @(posedge clk);
                        sink_hold = 1'b0;
                    end
                    repeat (40) random_req(0);
                join
            end
            sink_idle_on = (ph != 3);
            repeat (270) random_req(ph != 3);
            wait_drained();
        end

        $display("covered %0d requests, %0d results checked, %0d scrolls",
                 sent, sb.checked, sb.scrolls);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_text_terminal_writer: done, clean");
        end else begin
            $display("tb_text_terminal_writer: done, errors");
        end
        $finish;
    end
endmodule

### text_terminal_writer.f
rtl/ttw_pkg.sv
rtl/ttw_front.sv
rtl/ttw_back.sv
rtl/text_terminal_writer.sv
test/tb_text_terminal_writer.sv
